### rtl/event_time_window_framer_top_assert.svh
// Assertion macros shared by the framer checker.
`ifndef EVENT_TIME_WINDOW_FRAMER_TOP_ASSERT_SVH
`define EVENT_TIME_WINDOW_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define ETWF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, held off during reset.
`define ETWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### rtl/etwf_pkg.sv
// Shared constants, codes and control types of the event time window framer.
package etwf_pkg;

	// Ring and field sizes
	localparam int unsigned HistoryDepth = 4096;
	localparam int unsigned SlotW        = $clog2(HistoryDepth);
	localparam int unsigned CountW       = SlotW + 1;
	localparam int unsigned StampW       = 48;
	localparam int unsigned DurW         = 24;
	localparam int unsigned StepW        = 24;
	localparam int unsigned EventsW      = 13;
	localparam int unsigned StatusW      = 3;
	localparam int unsigned CfgIdxW      = 2;
	localparam int unsigned CfgDataW     = 24;
	localparam int unsigned InDataW      = ((StampW + 7) / 8) * 8;
	localparam int unsigned OutFieldsW   = 3 * SlotW;
	localparam int unsigned OutDataW     = ((OutFieldsW + 7) / 8) * 8;

	localparam logic [CountW-1:0] FullCount = CountW'(HistoryDepth);

	// Register indexes
	localparam logic [CfgIdxW-1:0] CFG_FRAME_DUR  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MIN_STEP   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MIN_EVENTS = 2'd2;

	// Register reset values
	localparam logic [DurW-1:0]    FrameDurReset  = 24'd10000;
	localparam logic [StepW-1:0]   MinStepReset   = 24'd1000;
	localparam logic [EventsW-1:0] MinEventsReset = 13'd1000;

	// Request kinds on the input stream
	localparam logic CMD_PUSH    = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// Frame decision codes
	typedef enum logic [StatusW-1:0] {
		ST_READY      = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_SPAN_SHORT = 3'd2,
		ST_STEP_SHORT = 3'd3,
		ST_FEW_EVENTS = 3'd4
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    push;
		logic    rd_oldest;
		logic    pend_early;
		status_t early_code;
		logic    walk_start;
		logic    walk_rd;
		logic    pend_frame;
		logic    load_out;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;
		logic span_ok;
		logic step_ok;
		logic walk_hit;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/event_time_window_framer_top.sv
// Event time window framer: stream ports, configuration port, sequencer and datapath.
//
// Keeps the last 4096 event timestamps (microseconds) in a ring and decides on
// frame requests. An event push (s_tuser = 0) is taken every cycle while the
// block is idle, also while a result waits on the master side. A frame request
// (s_tuser = 1) holds the input until it is decided: at once when the ring is
// empty, after the span and step checks when either fails, and after the
// backward walk otherwise, which reads one stamp per cycle from the
// single-read ring memory; no new request or push is taken meanwhile. The
// result shows on m_tvalid at the same edge that lets the block take input
// again. A result leaves through an output register, so pushes go on while
// it waits; a request that finishes while an earlier result is still not
// taken holds in its emit state until m_tready frees the output register.
// The ring needs no clearing pass after reset: only slots written since
// reset are read.
module event_time_window_framer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [etwf_pkg::InDataW-1:0]      s_tdata,   // stamp_us
	input  logic [0:0]                        s_tuser,   // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [etwf_pkg::OutDataW-1:0]     m_tdata,   // begin_slot, end_slot, event_span, zero pad
	output logic [etwf_pkg::StatusW-1:0]      m_tuser,   // status
	input  logic                              cfg_we,
	input  logic [etwf_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [etwf_pkg::CfgDataW-1:0]     cfg_data
);
	import etwf_pkg::*;

	ctl_cmd_t         cmd;
	dp_stat_t         stat;
	status_t          out_status;
	logic [SlotW-1:0] out_begin;
	logic [SlotW-1:0] out_end;
	logic [SlotW-1:0] out_span;

	// Sequencer
	etwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser[0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Ring and compare datapath
	etwf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_stamp   (s_tdata[StampW-1:0]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_begin  (out_begin),
		.out_end    (out_end),
		.out_span   (out_span)
	);

	// Result packing
	assign m_tdata = {{(OutDataW - OutFieldsW){1'b0}}, out_span, out_end, out_begin};
	assign m_tuser = out_status;

endmodule

### rtl/etwf_ctrl.sv
// Request sequencer of the framer: push, checks, backward walk, result hand-off.
module etwf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	input  etwf_pkg::dp_stat_t stat,
	output etwf_pkg::ctl_cmd_t cmd
);
	import etwf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CHK  = 4'b0010,
		S_WALK = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.early_code = ST_READY;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == CMD_PUSH) begin
						cmd.push = 1'b1;
					end else if (stat.empty) begin
						cmd.pend_early = 1'b1;
						cmd.early_code = ST_EMPTY;
						state_d        = S_EMIT;
					end else begin
						cmd.rd_oldest = 1'b1;
						state_d       = S_CHK;
					end
				end
			end
			S_CHK: begin
				// oldest stamp is in the read register now
				if (!stat.span_ok) begin
					cmd.pend_early = 1'b1;
					cmd.early_code = ST_SPAN_SHORT;
					state_d        = S_EMIT;
				end else if (!stat.step_ok) begin
					cmd.pend_early = 1'b1;
					cmd.early_code = ST_STEP_SHORT;
					state_d        = S_EMIT;
				end else begin
					cmd.walk_start = 1'b1;
					state_d        = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.walk_hit) begin
					cmd.pend_frame = 1'b1;
					state_d        = S_EMIT;
				end else begin
					cmd.walk_rd = 1'b1;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/etwf_datapath.sv
// Stamp ring, pointers, settings, window compare and result registers of the framer.
module etwf_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  etwf_pkg::ctl_cmd_t                cmd,
	output etwf_pkg::dp_stat_t                stat,
	input  logic [etwf_pkg::StampW-1:0]       in_stamp,
	input  logic                              cfg_we,
	input  logic [etwf_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [etwf_pkg::CfgDataW-1:0]     cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output etwf_pkg::status_t                 out_status,
	output logic [etwf_pkg::SlotW-1:0]        out_begin,
	output logic [etwf_pkg::SlotW-1:0]        out_end,
	output logic [etwf_pkg::SlotW-1:0]        out_span
);
	import etwf_pkg::*;

	logic [StampW-1:0]  ring_mem [HistoryDepth];
	logic [StampW-1:0]  rd_data_q;
	logic [SlotW-1:0]   oldest_q;
	logic [CountW-1:0]  held_q;
	logic [StampW-1:0]  newest_q;
	logic [StampW-1:0]  last_frame_q;
	logic [DurW-1:0]    frame_dur_q;
	logic [StepW-1:0]   min_step_q;
	logic [EventsW-1:0] min_events_q;
	logic [SlotW-1:0]   pos_q;
	logic [SlotW-1:0]   pos_s1;
	logic               walk_vld_s1;
	status_t            pend_status_q;
	logic [SlotW-1:0]   pend_begin_q;
	logic [SlotW-1:0]   pend_end_q;
	logic [SlotW-1:0]   pend_span_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [SlotW-1:0]   out_begin_q;
	logic [SlotW-1:0]   out_end_q;
	logic [SlotW-1:0]   out_span_q;

	logic               full;
	logic [SlotW-1:0]   newest_pos;
	logic [SlotW-1:0]   end_slot;
	logic [SlotW-1:0]   wr_addr;
	logic [SlotW-1:0]   rd_addr;
	logic               rd_en;
	logic [StampW:0]    dur_diff;
	logic [StampW-1:0]  dur_sat;
	logic               ge_dur;
	logic [StampW:0]    step_diff;
	logic [StampW-1:0]  step_sat;
	logic [SlotW-1:0]   span;

	// Ring addressing; slots wrap naturally at the ring depth
	assign full       = (held_q == FullCount);
	assign newest_pos = SlotW'(held_q - CountW'(1));
	assign end_slot   = oldest_q + newest_pos;
	assign wr_addr    = full ? oldest_q : (oldest_q + held_q[SlotW-1:0]);
	assign rd_en      = cmd.rd_oldest | cmd.walk_rd;
	assign rd_addr    = cmd.rd_oldest ? oldest_q : (oldest_q + pos_q);

	// Stamp memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_mem[wr_addr] <= in_stamp;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	// Saturating newest-minus-read compare against the frame duration
	assign dur_diff = {1'b0, newest_q} - {1'b0, rd_data_q};
	assign dur_sat  = dur_diff[StampW] ? '0 : dur_diff[StampW-1:0];
	assign ge_dur   = (dur_sat >= StampW'(frame_dur_q));

	// Saturating step since the last frame
	assign step_diff = {1'b0, newest_q} - {1'b0, last_frame_q};
	assign step_sat  = step_diff[StampW] ? '0 : step_diff[StampW-1:0];

	assign span = newest_pos - pos_s1;

	assign stat.empty    = (held_q == '0);
	assign stat.span_ok  = ge_dur;
	assign stat.step_ok  = (step_sat >= StampW'(min_step_q));
	assign stat.walk_hit = walk_vld_s1 & ge_dur;
	assign stat.out_free = ~out_valid_q | out_ready;

	// Settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_dur_q  <= FrameDurReset;
			min_step_q   <= MinStepReset;
			min_events_q <= MinEventsReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_DUR:  frame_dur_q  <= cfg_data[DurW-1:0];
				CFG_MIN_STEP:   min_step_q   <= cfg_data[StepW-1:0];
				CFG_MIN_EVENTS: min_events_q <= cfg_data[EventsW-1:0];
				default: ;
			endcase
		end
	end

	// Fill level, oldest slot and last frame stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			oldest_q     <= '0;
			last_frame_q <= '0;
		end else begin
			if (cmd.push) begin
				if (full) begin
					oldest_q <= oldest_q + SlotW'(1);
				end else begin
					held_q <= held_q + CountW'(1);
				end
			end
			if (cmd.pend_frame) begin
				last_frame_q <= newest_q;
			end
		end
	end

	// Newest stamp kept beside the ring
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			newest_q <= in_stamp;
		end
	end

	// Backward walk: issue position and the position of the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_vld_s1 <= 1'b0;
		end else begin
			walk_vld_s1 <= cmd.walk_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			pos_q <= newest_pos;
		end else if (cmd.walk_rd) begin
			pos_s1 <= pos_q;
			// position zero always passes, so holding there is safe
			if (pos_q != '0) begin
				pos_q <= pos_q - SlotW'(1);
			end
		end
	end

	// Pending result
	always_ff @(posedge clk) begin
		if (cmd.pend_early) begin
			pend_status_q <= cmd.early_code;
			pend_begin_q  <= '0;
			pend_end_q    <= '0;
			pend_span_q   <= '0;
		end else if (cmd.pend_frame) begin
			pend_status_q <= ({1'b0, span} < min_events_q) ? ST_FEW_EVENTS : ST_READY;
			pend_begin_q  <= oldest_q + pos_s1;
			pend_end_q    <= end_slot;
			pend_span_q   <= span;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= pend_status_q;
			out_begin_q  <= pend_begin_q;
			out_end_q    <= pend_end_q;
			out_span_q   <= pend_span_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_begin  = out_begin_q;
	assign out_end    = out_end_q;
	assign out_span   = out_span_q;

endmodule

### rtl/etwf_checker.sv
// Port-level checks of the framer and their binding to the top level.
`include "event_time_window_framer_top_assert.svh"

module etwf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [0:0]                        s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [etwf_pkg::OutDataW-1:0]     m_tdata,
	input logic [etwf_pkg::StatusW-1:0]      m_tuser
);
	import etwf_pkg::*;

	// A result that is not taken stays as it is
	`ETWF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Early decisions carry no window
	`ETWF_ASSERT_IMPLY(a_early_zero, clk, arst_n, m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_SPAN_SHORT || m_tuser == ST_STEP_SHORT), m_tdata == '0)

	// A found window spans from its begin slot to its end slot around the ring
	`ETWF_ASSERT_IMPLY(a_span_slots, clk, arst_n, m_tvalid && (m_tuser == ST_READY || m_tuser == ST_FEW_EVENTS), m_tdata[3*SlotW-1:2*SlotW] == SlotW'(m_tdata[2*SlotW-1:SlotW] - m_tdata[SlotW-1:0]))

	// A push from an idle block never makes a result
	`ETWF_ASSERT_NEXT(a_push_silent, clk, arst_n, s_tvalid && s_tready && (s_tuser[0] == CMD_PUSH) && !m_tvalid, !m_tvalid)

endmodule

bind event_time_window_framer_top etwf_checker u_etwf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
